/* rtl/core/c8_pkg.sv */
// Package for the CHIP-8 core: sizes, command codes, controller states,
// and the command/status structs between the controller and the datapath.
// No dependencies.
package c8_pkg;

  localparam int unsigned MemBytes     = 4096;
  localparam int unsigned StackEntries = 16;
  localparam int unsigned ScreenWidth  = 64;
  localparam int unsigned ScreenHeight = 32;
  localparam logic [11:0] StartReset   = 12'h200;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_ROW   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    HALT_NONE  = 2'd0,
    HALT_OVER  = 2'd1,
    HALT_UNDER = 2'd2
  } halt_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_DECODE,
    ST_CLEAR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_STORE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch input item
    logic simple;      // run write/tick/row command
    logic fetch_hi;    // issue read of PC
    logic fetch_lo;    // latch high byte, read PC+1
    logic decode;      // latch opcode, execute ops that need no loop
    logic clear_row;   // clear row at loop counter
    logic draw_rd;     // read sprite byte, row
    logic draw_wr;     // xor and write row
    logic store;       // write V[i] to memory
    logic load_rd;     // issue read for load
    logic load_wr;     // write loaded byte to V[i]
    logic step;        // advance loop counter
    logic finish;      // present result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       halted;
    logic       is_clear;
    logic       is_draw;
    logic       is_store;
    logic       is_load;
    logic       last;    // loop counter at last element
  } sts_t;

endpackage

/* rtl/core/c8_ctrl.sv */
// Controller state machine of the CHIP-8 core.
// Depends on c8_pkg.
module c8_ctrl import c8_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic   out_free_i,
  input  sts_t   sts_i,
  output ctl_t   ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_FETCH_HI;
      ST_FETCH_HI: begin
        if (sts_i.cmd == CMD_EXEC && !sts_i.halted) state_d = ST_FETCH_LO;
        else state_d = ST_DONE;
      end
      ST_FETCH_LO: state_d = ST_DECODE;
      ST_DECODE: begin
        if (sts_i.is_clear)      state_d = ST_CLEAR;
        else if (sts_i.is_draw)  state_d = ST_DRAW_RD;
        else if (sts_i.is_store) state_d = ST_STORE;
        else if (sts_i.is_load)  state_d = ST_LOAD_RD;
        else                     state_d = ST_DONE;
      end
      ST_CLEAR:    if (sts_i.last) state_d = ST_DONE;
      ST_DRAW_RD:  state_d = ST_DRAW_WR;
      ST_DRAW_WR:  state_d = sts_i.last ? ST_DONE : ST_DRAW_RD;
      ST_STORE:    if (sts_i.last) state_d = ST_DONE;
      ST_LOAD_RD:  state_d = ST_LOAD_WR;
      ST_LOAD_WR:  state_d = sts_i.last ? ST_DONE : ST_LOAD_RD;
      ST_DONE:     if (out_free_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.take = in_valid_i;
      end
      ST_FETCH_HI: begin
        ctl_o.simple   = !(sts_i.cmd == CMD_EXEC);
        ctl_o.fetch_hi = 1'b1;
      end
      ST_FETCH_LO: ctl_o.fetch_lo = 1'b1;
      ST_DECODE:   ctl_o.decode = 1'b1;
      ST_CLEAR: begin
        ctl_o.clear_row = 1'b1;
        ctl_o.step      = 1'b1;
      end
      ST_DRAW_RD:  ctl_o.draw_rd = 1'b1;
      ST_DRAW_WR: begin
        ctl_o.draw_wr = 1'b1;
        ctl_o.step    = 1'b1;
      end
      ST_STORE: begin
        ctl_o.store = 1'b1;
        ctl_o.step  = 1'b1;
      end
      ST_LOAD_RD:  ctl_o.load_rd = 1'b1;
      ST_LOAD_WR: begin
        ctl_o.load_wr = 1'b1;
        ctl_o.step    = 1'b1;
      end
      ST_DONE:     ctl_o.finish = out_free_i;
      default:     ;
    endcase
  end

endmodule

/* rtl/core/c8_dpath.sv */
// Datapath of the CHIP-8 core: memory, frame buffer, registers, stack,
// timers, and the result register. Depends on c8_pkg.
module c8_dpath import c8_pkg::*; #(
  parameter int unsigned StackDepth = StackEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic [1:0]  cmd_i,
  input  logic [11:0] mem_address_i,
  input  logic [7:0]  mem_data_i,
  input  logic [7:0]  random_byte_i,
  input  logic [4:0]  row_select_i,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  output logic [1:0]  status_o,
  output logic [11:0] program_counter_o,
  output logic [15:0] executed_opcode_o,
  output logic [63:0] row_pixels_o,
  output logic        sound_on_o
);

  localparam int unsigned SpW = $clog2(StackDepth);
  localparam int unsigned SdW = $clog2(StackDepth + 1);

  // memories
  logic [7:0]  mem_q [MemBytes];
  logic [7:0]  mem_rd_q;
  logic [SpW-1:0] stk_idx;
  logic [11:0] stk_q [StackDepth];

  // frame buffer with row valid bits
  logic [63:0] fb_q [ScreenHeight];
  logic [ScreenHeight-1:0] fb_vld_q;
  logic [63:0] fb_rd_q;

  logic [7:0]  v_q [16];
  logic [15:0] i_q;
  logic [11:0] pc_q;
  logic [SdW-1:0] sp_q;
  logic [7:0]  dt_q, st_q;
  logic [1:0]  halt_q;

  // latched input item
  logic [1:0]  cmd_q;
  logic [11:0] addr_q;
  logic [7:0]  wdat_q, rnd_q;
  logic [4:0]  rsel_q;

  logic [15:0] op_q;
  logic [7:0]  hi_q;
  logic [4:0]  cnt_q;
  logic        hit_q;

  // during decode the low opcode byte is still in mem_rd_q; op_q holds the
  // whole word from then on
  logic [15:0] op_new, op_w;
  assign op_new = {hi_q, mem_rd_q};
  assign op_w   = ctl_i.decode ? op_new : op_q;

  logic [3:0]  x, y, n;
  logic [7:0]  nn, vx, vy;
  logic [11:0] nnn;
  assign x   = op_w[11:8];
  assign y   = op_w[7:4];
  assign n   = op_w[3:0];
  assign nn  = op_w[7:0];
  assign nnn = op_w[11:0];
  assign vx  = v_q[x];
  assign vy  = v_q[y];

  assign sts_o.cmd      = cmd_q;
  assign sts_o.halted   = (halt_q != HALT_NONE);
  assign sts_o.is_clear = (op_w[15:12] == 4'h0) && (nn == 8'hE0);
  assign sts_o.is_draw  = (op_w[15:12] == 4'hD) && (n != 4'd0);
  assign sts_o.is_store = (op_w[15:12] == 4'hF) && (nn == 8'h55);
  assign sts_o.is_load  = (op_w[15:12] == 4'hF) && (nn == 8'h65);
  assign sts_o.last     = ctl_i.clear_row ? (cnt_q == 5'd31) :
                          (op_w[15:12] == 4'hD) ? (cnt_q[3:0] == n - 4'd1) :
                          (cnt_q[3:0] == x);

  // draw geometry; sprite byte is in mem_rd_q during draw_wr
  logic [4:0]  drow;
  logic [5:0]  dcol;
  logic [63:0] spr_mask, cur_row;
  logic [7:0]  vy_plus;
  logic        draw_hit;
  assign vy_plus  = vy + {4'd0, cnt_q[3:0]};
  assign drow     = vy_plus[4:0];
  assign dcol     = vx[5:0];
  // sprite placed at leftmost then rotated right by column, wrapping
  assign spr_mask = {mem_rd_q, 56'd0} >> dcol | {mem_rd_q, 56'd0} << (7'd64 - {1'b0, dcol});
  assign cur_row  = fb_vld_q[drow] ? fb_rd_q : 64'd0;
  assign draw_hit = hit_q | ((cur_row & spr_mask) != 64'd0);

  logic [11:0] maddr;
  always_comb begin
    maddr = pc_q;
    if (ctl_i.fetch_lo) maddr = pc_q + 12'd1;
    else if (ctl_i.fetch_hi) maddr = ctl_i.simple ? addr_q : pc_q;
    else if (ctl_i.draw_rd || ctl_i.load_rd || ctl_i.store)
      maddr = i_q[11:0] + {8'd0, cnt_q[3:0]};
  end

  logic       mem_we;
  logic [7:0] mem_wd;
  assign mem_we = (ctl_i.simple && cmd_q == CMD_WRITE) || ctl_i.store;
  assign mem_wd = ctl_i.store ? v_q[cnt_q[3:0]] : wdat_q;

  assign stk_idx = sp_q[SpW-1:0] - SpW'(1);

  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem_q[maddr];
    fb_rd_q  <= fb_q[drow];
    if (mem_we) mem_q[maddr] <= mem_wd;
    if (ctl_i.clear_row) fb_q[cnt_q] <= 64'd0;
    if (ctl_i.draw_wr) fb_q[drow] <= cur_row ^ spr_mask;
    if (ctl_i.decode && op_w[15:12] == 4'h2 && sp_q < SdW'(StackDepth))
      stk_q[sp_q[SpW-1:0]] <= pc_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      cmd_q  <= cmd_i;
      addr_q <= mem_address_i;
      wdat_q <= mem_data_i;
      rnd_q  <= random_byte_i;
      rsel_q <= row_select_i;
    end
    if (ctl_i.fetch_lo) hi_q <= mem_rd_q;
  end

  logic [8:0] sum;
  logic [7:0] vr;
  logic       vr_we, vf_we, vf;

  always_comb begin
    sum   = {1'b0, vx} + {1'b0, vy};
    vr    = 8'd0;
    vr_we = 1'b0;
    vf_we = 1'b0;
    vf    = 1'b0;
    case (op_w[15:12])
      4'h6: begin vr = nn; vr_we = 1'b1; end
      4'h7: begin vr = vx + nn; vr_we = 1'b1; end
      4'h8: begin
        vr_we = 1'b1;
        case (n)
          4'h0: vr = vy;
          4'h1: vr = vx | vy;
          4'h2: vr = vx & vy;
          4'h3: vr = vx ^ vy;
          4'h4: begin vr = sum[7:0]; vf = sum[8]; vf_we = 1'b1; end
          4'h5: begin vr = vx - vy; vf = vx >= vy; vf_we = 1'b1; end
          4'h6: begin vr = vx >> 1; vf = vx[0]; vf_we = 1'b1; end
          4'h7: begin vr = vy - vx; vf = vy >= vx; vf_we = 1'b1; end
          4'hE: begin vr = vx << 1; vf = vx[7]; vf_we = 1'b1; end
          default: vr_we = 1'b0;
        endcase
      end
      4'hC: begin vr = rnd_q & nn; vr_we = 1'b1; end
      4'hD: begin vr = 8'd0; vf = 1'b0; vf_we = (n == 4'd0); end
      4'hF: begin
        if (nn == 8'h07) begin vr = dt_q; vr_we = 1'b1; end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 16; k++) v_q[k] <= 8'd0;
      i_q      <= 16'd0;
      pc_q     <= StartReset;
      sp_q     <= '0;
      dt_q     <= 8'd0;
      st_q     <= 8'd0;
      halt_q   <= HALT_NONE;
      fb_vld_q <= '0;
      op_q     <= 16'd0;
      cnt_q    <= 5'd0;
      hit_q    <= 1'b0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_wdata_i;
      if (ctl_i.take) begin
        cnt_q <= 5'd0;
        hit_q <= 1'b0;
        op_q  <= 16'd0;
      end
      if (ctl_i.simple && cmd_q == CMD_TICK) begin
        if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
        if (st_q != 8'd0) st_q <= st_q - 8'd1;
      end
      if (ctl_i.fetch_lo) pc_q <= pc_q + 12'd2;
      if (ctl_i.decode) begin
        op_q <= op_new;
        // flag lands after Vx, so VF as target keeps the flag
        if (vr_we && !(vf_we && x == 4'd15)) v_q[x] <= vr;
        if (vf_we) v_q[15] <= {7'd0, vf};
        case (op_w[15:12])
          4'h0: if (nn == 8'hEE) begin
            if (sp_q == '0) halt_q <= HALT_UNDER;
            else begin
              sp_q <= sp_q - SdW'(1);
              pc_q <= stk_q[stk_idx];
            end
          end
          4'h1: pc_q <= nnn;
          4'h2: begin
            if (sp_q >= SdW'(StackDepth)) halt_q <= HALT_OVER;
            else begin
              sp_q <= sp_q + SdW'(1);
              pc_q <= nnn;
            end
          end
          4'h3: if (vx == nn) pc_q <= pc_q + 12'd2;
          4'h4: if (vx != nn) pc_q <= pc_q + 12'd2;
          4'h5: if (vx == vy) pc_q <= pc_q + 12'd2;
          4'h9: if (vx != vy) pc_q <= pc_q + 12'd2;
          4'hA: i_q <= {4'd0, nnn};
          4'hB: pc_q <= nnn + {4'd0, v_q[0]};
          4'hF: begin
            if (nn == 8'h15) dt_q <= vx;
            if (nn == 8'h18) st_q <= vx;
            if (nn == 8'h1E) i_q <= i_q + {8'd0, vx};
          end
          default: ;
        endcase
      end
      if (ctl_i.clear_row) fb_vld_q[cnt_q] <= 1'b0;
      if (ctl_i.draw_wr) begin
        fb_vld_q[drow] <= 1'b1;
        hit_q <= draw_hit;
        // VF written once, with the last row: VX/VY stay fixed while drawing
        if (sts_o.last) v_q[15] <= {7'd0, draw_hit};
      end
      if (ctl_i.load_wr) v_q[cnt_q[3:0]] <= mem_rd_q;
      if (ctl_i.step) cnt_q <= cnt_q + 5'd1;
    end
  end

  // result register
  logic [1:0]  res_status_q;
  logic [11:0] res_pc_q;
  logic [15:0] res_op_q;
  logic [63:0] res_row_q;
  logic        res_snd_q;
  always_ff @(posedge clk_i) begin
    if (ctl_i.finish) begin
      res_status_q <= halt_q;
      res_pc_q     <= pc_q;
      res_op_q     <= op_q;
      res_row_q    <= (cmd_q == CMD_ROW && fb_vld_q[rsel_q]) ? fb_q[rsel_q] : 64'd0;
      res_snd_q    <= (st_q != 8'd0);
    end
  end
  assign status_o          = res_status_q;
  assign program_counter_o = res_pc_q;
  assign executed_opcode_o = res_op_q;
  assign row_pixels_o      = res_row_q;
  assign sound_on_o        = res_snd_q;

endmodule

/* rtl/core/chip8_cpu_core.sv */
// Top level of the CHIP-8 core.
// Depends on c8_pkg, c8_ctrl, c8_dpath.
//
// channel  dir  content
// s_axis   in   tdata[34:0]: command, mem_address, mem_data, random_byte, row_select
// m_axis   out  tdata[94:0]: status, program_counter, executed_opcode, row_pixels, sound_on
// cfg      in   start_address (12 bits), write enable strobe
//
// One item at a time. Simple commands and an execute while halted pass through
// IDLE, FETCH_HI and DONE; execute adds FETCH_LO and DECODE, then a loop for
// screen clear (one row per step), draw (a read and a write per sprite row), FX55
// (one write per register) and FX65 (a read and a write per register), as the memory has a single port.
// Reset clears registers, timers, stack depth, halt and frame valid bits.
// A result waits in the output register; the next item is still accepted,
// but its result is held back until the register is transferred.
module chip8_cpu_core import c8_pkg::*; #(
  parameter int unsigned STACK_ENTRIES = StackEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // command, mem_address, mem_data, random_byte, row_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // status, program_counter, executed_opcode, row_pixels, sound_on
);

  ctl_t ctl;
  sts_t sts;
  logic out_vld_q;
  logic out_free;

  logic [1:0]  status;
  logic [11:0] pc;
  logic [15:0] op;
  logic [63:0] row;
  logic        snd;

  assign out_free = !out_vld_q || m_axis_tready;

  c8_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  c8_dpath #(.StackDepth(STACK_ENTRIES)) u_dpath (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .cmd_i         (s_axis_tdata[1:0]),
    .mem_address_i (s_axis_tdata[13:2]),
    .mem_data_i    (s_axis_tdata[21:14]),
    .random_byte_i (s_axis_tdata[29:22]),
    .row_select_i  (s_axis_tdata[34:30]),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .status_o      (status),
    .program_counter_o (pc),
    .executed_opcode_o (op),
    .row_pixels_o  (row),
    .sound_on_o    (snd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_vld_q <= 1'b0;
    else if (ctl.finish)  out_vld_q <= 1'b1;
    else if (m_axis_tready) out_vld_q <= 1'b0;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, snd, row, op, pc, status};

endmodule

/* tb/testbench.sv */
// Self-checking testbench for chip8_cpu_core: directed instruction checks, then random
// programs under varied stream back-pressure, ending with a stack overflow halt.
// Depends on c8_pkg and the chip8_cpu_core RTL.
`timescale 1ns / 100ps

module testbench;
  import c8_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 60;

  // FX sub-codes
  localparam logic [7:0] FxGetDelay = 8'h07;
  localparam logic [7:0] FxSetDelay = 8'h15;
  localparam logic [7:0] FxSetSound = 8'h18;
  localparam logic [7:0] FxAddIndex = 8'h1E;
  localparam logic [7:0] FxStore    = 8'h55;
  localparam logic [7:0] FxLoad     = 8'h65;

  // listed from the top bit down; status sits in the low bits of tdata
  typedef struct packed {
    logic        sound;
    logic [63:0] pixels;
    logic [15:0] opcode;
    logic [11:0] pc;
    logic [1:0]  status;
  } core_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  chip8_cpu_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the core state
  // ---------------------------------------------------------------------------
  logic [7:0]  mem_q [MemBytes];
  bit          mem_written [MemBytes];
  logic [63:0] frame_q [ScreenHeight];
  logic [7:0]  vreg [16];
  logic [15:0] idx_q;
  logic [11:0] pc_q;
  logic [11:0] ret_stack [StackEntries];
  int unsigned depth_q;
  logic [7:0]  delay_q, sound_q;
  halt_e       halt_q;

  core_res_t   pending_q[$];
  int unsigned fail_count = 0;
  int unsigned result_count = 0;
  int unsigned exec_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle = 0;   // percent
  int unsigned recv_idle = 0;   // percent
  int unsigned hold_cycles = 0; // long receiver stall request

  function automatic void xfer_pc2();
    pc_q = pc_q + 12'd2;
  endfunction

  function automatic void draw_sprite(int unsigned x, int unsigned y, int unsigned n);
    logic [7:0] bits;
    logic       hit;
    int unsigned r, c;
    hit = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      bits = mem_q[(idx_q + i) % MemBytes];
      r = (vreg[y] + i) % ScreenHeight;
      for (int unsigned j = 0; j < 8; j++) begin
        if (bits[7-j]) begin
          c = (vreg[x] + j) % ScreenWidth;
          if (frame_q[r][63-c]) hit = 1'b1;
          frame_q[r][63-c] = ~frame_q[r][63-c];
        end
      end
    end
    vreg[15] = {7'd0, hit};
  endfunction

  function automatic void run_opcode(logic [15:0] op, logic [7:0] rnd);
    int unsigned x, y;
    logic [7:0]  nn, vx, vy, f;
    logic [11:0] nnn;
    x = 32'(op[11:8]);
    y = 32'(op[7:4]);
    nn = op[7:0];
    nnn = op[11:0];
    vx = vreg[x];
    vy = vreg[y];
    case (op[15:12])
      4'h0: begin
        if (nn == 8'hE0) begin
          foreach (frame_q[r]) frame_q[r] = '0;
        end else if (nn == 8'hEE) begin
          if (depth_q == 0) halt_q = HALT_UNDER;
          else begin
            depth_q--;
            pc_q = ret_stack[depth_q];
          end
        end
      end
      4'h1: pc_q = nnn;
      4'h2: begin
        if (depth_q >= StackEntries) halt_q = HALT_OVER;
        else begin
          ret_stack[depth_q] = pc_q;
          depth_q++;
          pc_q = nnn;
        end
      end
      4'h3: if (vx == nn) xfer_pc2();
      4'h4: if (vx != nn) xfer_pc2();
      4'h5: if (vx == vy) xfer_pc2();
      4'h6: vreg[x] = nn;
      4'h7: vreg[x] = vx + nn;
      4'h8: begin
        case (op[3:0])
          4'h0: vreg[x] = vy;
          4'h1: vreg[x] = vx | vy;
          4'h2: vreg[x] = vx & vy;
          4'h3: vreg[x] = vx ^ vy;
          4'h4: begin
            f = ({1'b0, vx} + {1'b0, vy} > 9'hFF) ? 8'd1 : 8'd0;
            vreg[x] = vx + vy; vreg[15] = f;
          end
          4'h5: begin
            f = (vx >= vy) ? 8'd1 : 8'd0;
            vreg[x] = vx - vy; vreg[15] = f;
          end
          4'h6: begin
            f = {7'd0, vx[0]};
            vreg[x] = vx >> 1; vreg[15] = f;
          end
          4'h7: begin
            f = (vy >= vx) ? 8'd1 : 8'd0;
            vreg[x] = vy - vx; vreg[15] = f;
          end
          4'hE: begin
            f = {7'd0, vx[7]};
            vreg[x] = vx << 1; vreg[15] = f;
          end
          default: ;
        endcase
      end
      4'h9: if (vx != vy) xfer_pc2();
      4'hA: idx_q = {4'd0, nnn};
      4'hB: pc_q = nnn + {4'd0, vreg[0]};
      4'hC: vreg[x] = rnd & nn;
      4'hD: draw_sprite(x, y, 32'(op[3:0]));
      4'hE: ;
      default: begin
        case (nn)
          FxGetDelay: vreg[x] = delay_q;
          FxSetDelay: delay_q = vx;
          FxSetSound: sound_q = vx;
          FxAddIndex: idx_q = idx_q + {8'd0, vx};
          FxStore: for (int unsigned i = 0; i <= x; i++) begin
            mem_q[(idx_q + i) % MemBytes] = vreg[i];
            mem_written[(idx_q + i) % MemBytes] = 1'b1;
          end
          FxLoad: for (int unsigned i = 0; i <= x; i++)
            vreg[i] = mem_q[(idx_q + i) % MemBytes];
          default: ;
        endcase
      end
    endcase
  endfunction

  // Advances the shadow state by one command and returns what the core should report.
  function automatic core_res_t core_step(cmd_e cmd, logic [11:0] addr, logic [7:0] data,
                                          logic [7:0] rnd, logic [4:0] row);
    core_res_t res;
    res = '0;
    case (cmd)
      CMD_WRITE: begin
        mem_q[addr] = data;
        mem_written[addr] = 1'b1;
      end
      CMD_EXEC: if (halt_q == HALT_NONE) begin
        res.opcode = {mem_q[pc_q], mem_q[pc_q + 12'd1]};
        xfer_pc2();
        run_opcode(res.opcode, rnd);
      end
      CMD_TICK: begin
        if (delay_q != 0) delay_q--;
        if (sound_q != 0) sound_q--;
      end
      default: res.pixels = frame_q[row];
    endcase
    res.status = halt_q;
    res.pc = pc_q;
    res.sound = (sound_q != 0);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------
  task automatic send_item(cmd_e cmd, logic [11:0] addr, logic [7:0] data,
                           logic [7:0] rnd, logic [4:0] row);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {5'd0, row, rnd, data, addr, cmd};
    pending_q.push_back(core_step(cmd, addr, data, rnd, row));
    if (cmd == CMD_EXEC) exec_count++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_byte(logic [11:0] addr, logic [7:0] data);
    send_item(CMD_WRITE, addr, data, 8'($urandom), 5'($urandom));
  endtask

  // writes random bytes wherever a range is still uninitialized
  task automatic fill_unwritten(logic [15:0] base, int unsigned n);
    logic [11:0] a;
    for (int unsigned i = 0; i < n; i++) begin
      a = 12'((base + i) % MemBytes);
      if (!mem_written[a]) write_byte(a, 8'($urandom));
    end
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    op = 16'($urandom);
    case ($urandom_range(19))
      0: op = (depth_q > 0 && $urandom_range(1)) ? 16'h00EE : 16'h00E0;
      1: op[15:12] = 4'h1;
      2: op = (depth_q < StackEntries - 1) ? {4'h2, op[11:0]} : {4'h6, op[11:0]};
      3: op[15:12] = 4'h3;
      4: op[15:12] = 4'h4;
      5: op[15:12] = 4'h5;
      6, 7: op[15:12] = 4'h6;
      8: op[15:12] = 4'h7;
      9, 10: op[15:12] = 4'h8;
      11: op[15:12] = 4'h9;
      12: op[15:12] = 4'hA;
      13: op[15:12] = 4'hB;
      14: op[15:12] = 4'hC;
      15, 16: op[15:12] = 4'hD;
      17: op[15:12] = 4'hE;
      default: begin
        op[15:12] = 4'hF;
        case ($urandom_range(7))
          0: op[7:0] = FxGetDelay;
          1: op[7:0] = FxSetDelay;
          2: op[7:0] = FxSetSound;
          3: op[7:0] = FxAddIndex;
          4: op[7:0] = FxStore;
          5: op[7:0] = FxLoad;
          default: ;  // key, font, BCD or unknown: no-op
        endcase
      end
    endcase
    return op;
  endfunction

  // Executes the word at PC; makes sure every byte the instruction reads was written.
  task automatic run_exec();
    logic [15:0] op;
    if (halt_q == HALT_NONE) begin
      op = random_opcode();
      if (!mem_written[pc_q]) write_byte(pc_q, op[15:8]);
      if (!mem_written[pc_q + 12'd1]) write_byte(pc_q + 12'd1, op[7:0]);
      op = {mem_q[pc_q], mem_q[pc_q + 12'd1]};
      if (op[15:12] == 4'hD) fill_unwritten(idx_q, 32'(op[3:0]));
      if (op[15:12] == 4'hF && op[7:0] == FxLoad) fill_unwritten(idx_q, 32'(op[11:8]) + 1);
    end
    send_item(CMD_EXEC, 12'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
  endtask

  task automatic exec_op(logic [15:0] op);
    write_byte(pc_q, op[15:8]);
    write_byte(pc_q + 12'd1, op[7:0]);
    run_exec();
  endtask

  task automatic read_row(logic [4:0] row);
    send_item(CMD_ROW, 12'($urandom), 8'($urandom), 8'($urandom), row);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_start(logic [11:0] addr);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = addr;
    pc_q = addr;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    exec_op(16'h6AFF);  // VA = FF
    exec_op(16'h6B01);
    exec_op(16'h8AB4);  // add with carry out
    exec_op(16'h8AB5);  // sub with borrow
    exec_op(16'h8AB7);  // reverse sub with borrow
    exec_op(16'h8AB6);
    exec_op(16'h8ABE);
    exec_op(16'h6A3E);  // sprite at x=62, y=30: wraps both ways
    exec_op(16'h6B1E);
    exec_op(16'hAFFE);  // I near top of memory, sprite bytes wrap
    exec_op(16'hDAB4);
    exec_op(16'hDAB4);  // redraw: every pixel collides
    read_row(5'd30);
    read_row(5'd1);
    exec_op(16'hFA18);  // sound on
    send_item(CMD_TICK, '0, '0, '0, '0);
    exec_op(16'hFA15);
    exec_op(16'hF207);
    exec_op(16'hFF1E);  // add VF to I
    exec_op(16'hF355);
    exec_op(16'hF365);
    exec_op(16'hCFFF);
    exec_op(16'h3000);  // skip if V0 == 00
    exec_op(16'h5AB0);
    exec_op(16'h9AB7);
    exec_op(16'hE59E);  // key opcode: no-op
    exec_op(16'h00E0);
    exec_op(16'hBFFF);  // jump wraps with V0
    exec_op(16'h00EE);  // returns from the call made before this test
  endtask

  task automatic test_random(int unsigned n, int unsigned s_idle, int unsigned r_idle,
                             bit stall);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int unsigned k = 0; k < n; k++) begin
      if (stall && k == n / 2) hold_cycles = 400;
      case ($urandom_range(19))
        0, 1: write_byte(12'($urandom), 8'($urandom));
        2, 3: send_item(CMD_TICK, 12'($urandom), 8'($urandom), 8'($urandom), 5'($urandom));
        4, 5: read_row(5'($urandom));
        default: run_exec();
      endcase
    end
  endtask

  task automatic test_stack_overflow();
    send_idle = 0;
    recv_idle = 0;
    while (halt_q == HALT_NONE) exec_op({4'h2, 12'($urandom)});
    exec_op(16'h6123);  // ignored while halted
    send_item(CMD_TICK, '0, '0, '0, '0);
    read_row(5'($urandom));
  endtask

  // receiver: random back-pressure, plus one long hold when requested
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", result_count, field, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    core_res_t got, want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("chip8_cpu_core test failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = core_res_t'(m_axis_tdata[94:0]);
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(got.pc), '0);
      end else begin
        want = pending_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.pc !== want.pc)
          report_mismatch("program_counter", 64'(got.pc), 64'(want.pc));
        if (got.opcode !== want.opcode)
          report_mismatch("opcode", 64'(got.opcode), 64'(want.opcode));
        if (got.pixels !== want.pixels) report_mismatch("row_pixels", got.pixels, want.pixels);
        if (got.sound !== want.sound)
          report_mismatch("sound_on", 64'(got.sound), 64'(want.sound));
      end
      result_count++;
    end
  end

  initial begin
    foreach (mem_written[a]) mem_written[a] = 1'b0;
    foreach (frame_q[r]) frame_q[r] = '0;
    foreach (vreg[r]) vreg[r] = '0;
    idx_q = '0;
    pc_q = StartReset;
    depth_q = 0;
    delay_q = '0;
    sound_q = '0;
    halt_q = HALT_NONE;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // one call first so the directed return does not halt the core
    exec_op(16'h2300);
    test_directed();
    set_start(12'h000);
    test_random(55, 15, 86, 1'b0);
    set_start(12'hFFF);  // fetch of PC+1 wraps to 0
    test_random(55, 86, 15, 1'b0);
    set_start(12'($urandom));
    test_random(55, 0, 0, 1'b1);
    test_stack_overflow();
    drain();

    if (pending_q.size() != 0) begin
      $display("%0d results never arrived", pending_q.size());
      fail_count++;
    end
    $display("Ran %0d transfers (%0d executes) over directed ops, three start addresses,",
             result_count, exec_count);
    $display("random programs under back-pressure, and a stack overflow halt.");
    if (fail_count == 0) begin
      $display("chip8_cpu_core test passed");
    end else begin
      $display("chip8_cpu_core test failed");
    end
    $finish;
  end

endmodule
